// ===== rtl/swm_pkg.sv =====
package swm_pkg;

    localparam int unsigned SAMPLE_W = 32;
    localparam int unsigned OUT_W    = 33;
    localparam int unsigned WS_W     = 7;

    localparam logic [WS_W-1:0] WS_RESET = WS_W'(3);

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic shift;
        logic load_age;
        logic count;
        logic load_rank;
        logic rotate;
    } t_cell_ctl;

endpackage

// ===== rtl/swm_in_if.sv =====
interface swm_in_if;
    import swm_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_new;

    modport source (output valid, sample, start_new, input ready);
    modport sink   (input valid, sample, start_new, output ready);
endinterface

// ===== rtl/swm_out_if.sv =====
interface swm_out_if;
    import swm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] median_x2;

    modport source (output valid, median_x2, input ready);
    modport sink   (input valid, median_x2, output ready);
endinterface

// ===== rtl/swm_cell.sv =====
module swm_cell #(
    parameter int IDX = 0,
    parameter int SW  = 32,
    parameter int AW  = 6,
    parameter int KW  = 7
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swm_pkg::t_cell_ctl     i_ctl,
    input  logic [KW-1:0]          i_k,
    input  logic signed [SW-1:0]   i_shift_val,
    output logic signed [SW-1:0]   o_val,
    input  logic signed [SW-1:0]   i_circ_val,
    input  logic [AW-1:0]          i_circ_tag,
    input  logic                   i_circ_vld,
    output logic signed [SW-1:0]   o_circ_val,
    output logic [AW-1:0]          o_circ_tag,
    output logic                   o_circ_vld
);
    import swm_pkg::*;

    logic signed [SW-1:0] r_val;
    logic signed [SW-1:0] r_circ_val;
    logic [AW-1:0]        r_circ_tag;
    logic                 r_circ_vld;
    logic [AW-1:0]        r_rank;
    logic                 w_in_win;
    logic                 w_less;

    assign w_in_win = KW'(IDX) < i_k;

    // ties broken by age so every rank in the window is distinct
    assign w_less = (i_circ_val < r_val) ||
                    ((i_circ_val == r_val) && (i_circ_tag < AW'(IDX)));

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_val <= i_shift_val;
        end
        if (i_ctl.load_age) begin
            r_rank <= '0;
        end else if (i_ctl.count && w_in_win && i_circ_vld && w_less) begin
            r_rank <= r_rank + AW'(1);
        end
        if (i_ctl.load_age) begin
            r_circ_val <= r_val;
            r_circ_tag <= AW'(IDX);
        end else if (i_ctl.load_rank) begin
            r_circ_val <= r_val;
            r_circ_tag <= r_rank;
        end else if (i_ctl.rotate) begin
            r_circ_val <= i_circ_val;
            r_circ_tag <= i_circ_tag;
        end
        if (!i_rst_n) begin
            r_circ_vld <= 1'b0;
        end else if (i_ctl.load_age || i_ctl.load_rank) begin
            r_circ_vld <= w_in_win;
        end else if (i_ctl.rotate) begin
            r_circ_vld <= i_circ_vld;
        end
    end

    assign o_val      = r_val;
    assign o_circ_val = r_circ_val;
    assign o_circ_tag = r_circ_tag;
    assign o_circ_vld = r_circ_vld;

endmodule

// ===== rtl/swm_ctrl.sv =====
module swm_ctrl #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32,
    parameter int AW          = 6,
    parameter int CNT_W       = 7,
    parameter int KW          = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [swm_pkg::WS_W-1:0]      i_cfg_wr_data,
    swm_in_if.sink                        i_in,
    swm_out_if.source                     o_out,
    output swm_pkg::t_cell_ctl            o_ctl,
    output logic [KW-1:0]                 o_k,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_tail_val,
    input  logic [AW-1:0]                 i_tail_tag,
    input  logic                          i_tail_vld
);
    import swm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOADA,
        S_COUNT,
        S_LOADB,
        S_SCAN,
        S_DONE
    } t_state;

    localparam logic [AW-1:0] LAST = AW'(WINDOW_MAX - 1);

    t_state                        r_state,   n_state;
    logic [CNT_W-1:0]              r_fill,    n_fill;
    logic [AW-1:0]                 r_cnt,     n_cnt;
    logic [WS_W-1:0]               r_ws;
    logic signed [SAMPLE_BITS-1:0] r_lo,      n_lo;
    logic signed [SAMPLE_BITS-1:0] r_hi,      n_hi;
    logic                          r_out_vld, n_out_vld;
    logic signed [OUT_W-1:0]       r_out,     n_out;
    logic [KW-1:0]                 w_k;
    logic [AW-1:0]                 w_half;
    logic [AW-1:0]                 w_lo_tag;
    logic                          w_accept;
    logic signed [OUT_W-1:0]       w_sum;

    always_comb begin
        if (r_ws == '0) begin
            w_k = KW'(1);
        end else if (KW'(r_ws) > KW'(WINDOW_MAX)) begin
            w_k = KW'(WINDOW_MAX);
        end else begin
            w_k = KW'(r_ws);
        end
    end

    assign w_half   = AW'(w_k >> 1);
    assign w_lo_tag = w_k[0] ? w_half : w_half - AW'(1);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_sum    = {{(OUT_W - SAMPLE_BITS){r_lo[SAMPLE_BITS-1]}}, r_lo} +
                      {{(OUT_W - SAMPLE_BITS){r_hi[SAMPLE_BITS-1]}}, r_hi};

    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_cnt     = r_cnt;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_out.ready;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.start_new) begin
                        n_fill = CNT_W'(1);
                    end else if (r_fill != CNT_W'(WINDOW_MAX)) begin
                        n_fill = r_fill + CNT_W'(1);
                    end
                    if (KW'(n_fill) >= w_k) begin
                        n_state = S_LOADA;
                    end
                end
            end
            S_LOADA: begin
                n_cnt   = '0;
                n_state = S_COUNT;
            end
            S_COUNT: begin
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_state = S_LOADB;
                end
            end
            S_LOADB: begin
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_tail_vld && i_tail_tag == w_lo_tag) begin
                    n_lo = i_tail_val;
                end
                if (i_tail_vld && i_tail_tag == w_half) begin
                    n_hi = i_tail_val;
                end
                n_cnt = r_cnt + AW'(1);
                if (r_cnt == LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out     = w_sum;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fill    <= '0;
            r_cnt     <= '0;
            r_ws      <= WS_RESET;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_ws <= i_cfg_wr_data;
            end
        end
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_out <= n_out;
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_vld;
    assign o_out.median_x2 = r_out;
    assign o_k             = w_k;
    assign o_sample        = $signed(i_in.sample[SAMPLE_BITS-1:0]);

    always_comb begin
        o_ctl           = '0;
        o_ctl.shift     = w_accept;
        o_ctl.load_age  = (r_state == S_LOADA);
        o_ctl.count     = (r_state == S_COUNT);
        o_ctl.load_rank = (r_state == S_LOADB);
        o_ctl.rotate    = (r_state == S_COUNT) || (r_state == S_SCAN);
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW_MAX))
        else $error("fill count above window capacity");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_k != '0) && (w_k <= KW'(WINDOW_MAX)))
        else $error("effective window out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.start_new) |=> (r_fill == CNT_W'(1)))
        else $error("start of sequence did not reset fill count");

    a_count_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT && r_cnt == LAST) |=> (r_state == S_LOADB))
        else $error("rank pass did not end after one full rotation");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !o_ctl.shift)
        else $error("cell line shifted during median scan");

endmodule

// ===== rtl/sliding_window_median.sv =====
// Running median over the last window_size samples (1 to WINDOW_MAX, 0 acts as 1,
// larger values act as WINDOW_MAX). Each accepted word shifts a sample into a row of
// WINDOW_MAX cells; once window_size samples have arrived since the last start_new,
// the block returns twice the median (the middle value doubled for an odd window,
// the sum of the two middle values for an even one) as a 33-bit signed word. A
// word that gives no result leaves the block idle and ready for the next word. A
// word that gives a result keeps the input not ready until the result is written
// to the output register, so no new sample is taken before the last is through: the
// sample copies circulate once around the whole cell row to rank every sample, then
// once more to pick out the middle ranks at the end of the row. The result sits in
// an output register, and the next word is taken while it waits. window_size may
// only be written while the block is idle.
module sliding_window_median #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [swm_pkg::WS_W-1:0] i_cfg_wr_data,
    swm_in_if.sink                   i_in,
    swm_out_if.source                o_out
);
    import swm_pkg::*;

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int KW    = (CNT_W > WS_W) ? CNT_W : WS_W;

    t_cell_ctl                     w_ctl;
    logic [KW-1:0]                 w_k;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic signed [SAMPLE_BITS-1:0] w_val      [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_circ_val [WINDOW_MAX];
    logic [AW-1:0]                 w_circ_tag [WINDOW_MAX];
    logic                          w_circ_vld [WINDOW_MAX];

    swm_ctrl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .AW          (AW),
        .CNT_W       (CNT_W),
        .KW          (KW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_ctl         (w_ctl),
        .o_k           (w_k),
        .o_sample      (w_sample),
        .i_tail_val    (w_circ_val[WINDOW_MAX-1]),
        .i_tail_tag    (w_circ_tag[WINDOW_MAX-1]),
        .i_tail_vld    (w_circ_vld[WINDOW_MAX-1])
    );

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        localparam int PREV = (g == 0) ? WINDOW_MAX - 1 : g - 1;

        logic signed [SAMPLE_BITS-1:0] w_shift_in;

        if (g == 0) begin : g_head
            assign w_shift_in = w_sample;
        end else begin : g_body
            assign w_shift_in = w_val[PREV];
        end

        swm_cell #(
            .IDX (g),
            .SW  (SAMPLE_BITS),
            .AW  (AW),
            .KW  (KW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_k         (w_k),
            .i_shift_val (w_shift_in),
            .o_val       (w_val[g]),
            .i_circ_val  (w_circ_val[PREV]),
            .i_circ_tag  (w_circ_tag[PREV]),
            .i_circ_vld  (w_circ_vld[PREV]),
            .o_circ_val  (w_circ_val[g]),
            .o_circ_tag  (w_circ_tag[g]),
            .o_circ_vld  (w_circ_vld[g])
        );
    end

endmodule

// ===== tb/swm_median_checker.sv =====
module swm_median_checker #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [swm_pkg::WS_W-1:0] i_cfg_wr_data,
    swm_in_if                        i_in,
    swm_out_if                       i_out,
    output int                       o_pending,
    output int                       o_fail_count
);
    import swm_pkg::*;

    logic signed [SAMPLE_W-1:0] hist [WINDOW_MAX];
    int                         hist_fill;
    int                         hist_wr;
    logic [WS_W-1:0]            win_size;
    logic signed [OUT_W-1:0]    median_q [$];
    logic signed [OUT_W-1:0]    exp_median;
    int                         mismatches = 0;

    function automatic void predict_median(input logic signed [SAMPLE_W-1:0] s,
                                           input logic sn);
        int                         k;
        int                         i;
        int                         j;
        logic signed [SAMPLE_W-1:0] sorted_win [WINDOW_MAX];
        logic signed [SAMPLE_W-1:0] v;
        logic signed [OUT_W-1:0]    lo;
        logic signed [OUT_W-1:0]    hi;
        k = int'(win_size);
        if (k < 1) k = 1;
        if (k > WINDOW_MAX) k = WINDOW_MAX;
        if (sn) begin
            hist_fill = 0;
            hist_wr   = 0;
        end
        hist[hist_wr] = s;
        hist_wr = (hist_wr + 1) % WINDOW_MAX;
        if (hist_fill < WINDOW_MAX) hist_fill++;
        if (hist_fill < k) return;
        // newest sample first, insertion sort into ascending order
        for (i = 0; i < k; i++) begin
            v = hist[(hist_wr + 2 * WINDOW_MAX - 1 - i) % WINDOW_MAX];
            j = i;
            while (j > 0 && sorted_win[j-1] > v) begin
                sorted_win[j] = sorted_win[j-1];
                j--;
            end
            sorted_win[j] = v;
        end
        if (k % 2 == 1) begin
            lo = sorted_win[k/2];
            hi = lo;
        end else begin
            lo = sorted_win[k/2-1];
            hi = sorted_win[k/2];
        end
        median_q.insert(median_q.size(), lo + hi);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hist_fill = 0;
            hist_wr   = 0;
            win_size  = WS_RESET;
            median_q.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (median_q.size() == 0) begin
                    $display("%0t: unexpected median_x2 word, expected none, got %0d",
                             $time, i_out.median_x2);
                    mismatches++;
                end else begin
                    exp_median = median_q.pop_front();
                    if (i_out.median_x2 !== exp_median) begin
                        $display("%0t: median_x2 mismatch, expected %0d, got %0d",
                                 $time, exp_median, i_out.median_x2);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) predict_median(i_in.sample, i_in.start_new);
            if (i_cfg_wr_en) win_size = i_cfg_wr_data;
        end
        o_pending    <= median_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import swm_pkg::*;

    localparam int WINDOW_MAX   = 64;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int LONG_HOLD    = 1000;
    localparam int PHASES       = 12;
    localparam int PHASE_WORDS  = 100;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fffffff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh80000000;

    logic            clk;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [WS_W-1:0] cfg_wr_data;
    int              pending;
    int              fail_count;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    bit hold_go      = 1'b0;
    bit hold_seen    = 1'b0;
    int hold_left    = 0;

    swm_in_if  in_ch ();
    swm_out_if out_ch ();

    sliding_window_median #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_W)
    ) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    swm_median_checker #(
        .WINDOW_MAX (WINDOW_MAX)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk) begin
        if (hold_go != hold_seen) begin
            hold_seen = hold_go;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("sliding_window_median test failed");
        $finish;
    end

    task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic sn);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.sample    <= s;
        in_ch.start_new <= sn;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic cfg_write(input logic [WS_W-1:0] v);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2, 3, 4: return SAMPLE_W'($urandom_range(0, 8)) - SAMPLE_W'(4);
            default: return $urandom;
        endcase
    endfunction

    function automatic void set_idling(input int mode);
        case (mode)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 49; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 49; end
            default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
        endcase
    endfunction

    initial begin
        logic [WS_W-1:0] ws_extremes [6];
        logic [WS_W-1:0] ws;
        int              p;
        int              n;
        ws_extremes = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2, 7'd6};
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample    = '0;
        in_ch.start_new = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // window of three after reset
        send_word(S_MAX, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b0);
        send_word(S_MIN, 1'b0);
        // restart, fill count starts again at one
        send_word(32'sd0, 1'b1);
        send_word(32'sd1, 1'b0);
        send_word(-32'sd1, 1'b0);
        send_word(32'sd5, 1'b0);
        // even window, extreme sums
        cfg_write(7'd2);
        send_word(S_MAX, 1'b1);
        send_word(S_MAX, 1'b0);
        send_word(S_MIN, 1'b1);
        send_word(S_MIN, 1'b0);
        send_word(S_MAX, 1'b0);
        // size grows mid-sequence
        cfg_write(7'd4);
        send_word(32'sd3, 1'b0);
        send_word(-32'sd7, 1'b0);
        // zero acts as one
        cfg_write(7'd0);
        send_word(S_MIN, 1'b1);
        send_word(S_MAX, 1'b0);
        // above the maximum acts as the maximum
        cfg_write(7'd127);
        send_word(32'sd7, 1'b1);
        send_word(32'sd9, 1'b0);

        for (p = 0; p < PHASES; p++) begin
            ws = (p < 6) ? ws_extremes[p] : WS_W'($urandom_range(0, 127));
            cfg_write(ws);
            set_idling(p % 4);
            if (p == 2) hold_go = ~hold_go;
            for (n = 0; n < PHASE_WORDS; n++) begin
                if (p == 5 && n == PHASE_WORDS / 2) begin
                    in_ch.valid <= 1'b0;
                    wait_drained();
                end
                send_word(rand_sample(), $urandom_range(0, 149) == 0);
            end
        end

        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("sliding_window_median test passed");
        end else begin
            $display("sliding_window_median test failed");
        end
        $finish;
    end

endmodule
